// ===== hw/rtl/stochastic_tumor_lattice_update_core_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the lattice update core
// Immediate-follow and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef STOCHASTIC_TUMOR_LATTICE_UPDATE_CORE_ASSERT_SVH
`define STOCHASTIC_TUMOR_LATTICE_UPDATE_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define STLU_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("stlu assertion failed");

// consequent must hold in the cycle after the antecedent
`define STLU_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("stlu assertion failed");

`endif

// ===== hw/rtl/stlu_pkg.sv =====
// ----------------------------------------------------------------------------
// stlu_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stlu_pkg;

   // default grid shape
   localparam int DEF_ROWS = 64;
   localparam int DEF_COLS = 64;

   // field widths
   localparam int POS_W    = 6;
   localparam int SPEC_W   = 3;
   localparam int DIR_W    = 3;
   localparam int FRAC_W   = 12;
   localparam int CNT_W    = 13;
   localparam int NUM_SPEC = 5;
   localparam int NUM_CNT  = NUM_SPEC + 1;
   localparam int PACK_W   = FRAC_W * NUM_SPEC;
   localparam int ACC_W    = FRAC_W + 3;

   // stream widths
   localparam int REQ_TDATA_W = 72;
   localparam int RSP_TDATA_W = 88;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = PACK_W;

   // opcodes
   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_GROWTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DIFFUSE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SPECIES = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_MUT1    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MUT2    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_MUT3    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_MUT4    = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_MUT5    = 3'd7;

   // neighbor direction codes
   localparam logic [DIR_W-1:0] DIR_UP_LAST    = 3'd2;
   localparam logic [DIR_W-1:0] DIR_DOWN_FIRST = 3'd5;
   localparam logic [DIR_W-1:0] DIR_UP_LEFT    = 3'd0;
   localparam logic [DIR_W-1:0] DIR_LEFT       = 3'd3;
   localparam logic [DIR_W-1:0] DIR_DOWN_LEFT  = 3'd5;
   localparam logic [DIR_W-1:0] DIR_UP_RIGHT   = 3'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT      = 3'd4;
   localparam logic [DIR_W-1:0] DIR_DOWN_RIGHT = 3'd7;

   // species codes
   localparam logic [SPEC_W-1:0] SPEC_EMPTY = 3'd0;
   localparam logic [SPEC_W-1:0] SPEC_MIN   = 3'd1;
   localparam logic [SPEC_W-1:0] SPEC_MAX   = 3'd5;

   // controller to datapath commands
   typedef struct packed {
      logic clr_wr;   // write zero at the clear pointer
      logic accept;   // capture the input item
      logic rd_nb;    // read neighbor address instead of target
      logic cap_tgt;  // capture target read data
      logic calc;     // evaluate the update or load
      logic wr_nb;    // write neighbor back
      logic wr_tgt;   // write target back, commit counts and result
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic clr_last;   // clear pointer at last entry
      logic is_update;  // captured item is an update
   } ctl_status_type;

endpackage

// ===== hw/rtl/stochastic_tumor_lattice_update_core.sv =====
// ----------------------------------------------------------------------------
// stochastic_tumor_lattice_update_core
// Toroidal cell grid with per-species counts, loaded and updated by items.
//
//   channel | dir | tdata / tuser fields (low bit up)
//   req     | in  | tuser: opcode; tdata: row_pos, col_pos, load_species,
//           |     |   direction, rand_grow, rand_mutate, rand_compete,
//           |     |   rand_diffuse, zero pad
//   rsp     | out | tdata: target_after, neighbor_after, count_empty,
//           |     |   count_s1..count_s5, zero pad
//   csr     | in  | csr_index, csr_data; register write
//
// Loads and updates pass through the grid memory in these steps: target
// read, neighbor read, compute, neighbor write (updates only) and target
// write. The next item is taken only in the idle state that follows the
// target write.
// After reset the grid is cleared one cell a cycle, all ROWS*COLS cells, with
// req_tready low; settings writes are taken throughout.
// A new item is accepted while the last result waits; its commit then waits
// for rsp_tready.
// ----------------------------------------------------------------------------
module stochastic_tumor_lattice_update_core #(
   parameter int ROWS = stlu_pkg::DEF_ROWS,
   parameter int COLS = stlu_pkg::DEF_COLS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // row_pos[5:0], col_pos[11:6], load_species[14:12], direction[17:15],
   // rand_grow[29:18], rand_mutate[41:30], rand_compete[53:42],
   // rand_diffuse[65:54], zero[71:66]
   input  logic [stlu_pkg::REQ_TDATA_W-1:0]  req_tdata,
   // opcode
   input  logic                              req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // target_after[2:0], neighbor_after[5:3], count_empty[18:6],
   // count_s1[31:19], count_s2[44:32], count_s3[57:45], count_s4[70:58],
   // count_s5[83:71], zero[87:84]
   output logic [stlu_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [stlu_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [stlu_pkg::CSR_DATA_W-1:0]   csr_data
);

   stlu_pkg::ctl_cmd_type    cmd;
   stlu_pkg::ctl_status_type status;

   // settings are always writable
   assign csr_ready = 1'b1;

   stlu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   stlu_datapath #(
      .ROWS (ROWS),
      .COLS (COLS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== hw/rtl/stlu_ctrl.sv =====
// ----------------------------------------------------------------------------
// stlu_ctrl
// Sequencer for the grid clear, the read/compute/write steps and the result.
// ----------------------------------------------------------------------------
`include "stochastic_tumor_lattice_update_core_assert.svh"

module stlu_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  stlu_pkg::ctl_status_type status,
   output stlu_pkg::ctl_cmd_type    cmd
);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_RDT  = 3'd2;
   localparam logic [2:0] S_RDN  = 3'd3;
   localparam logic [2:0] S_CALC = 3'd4;
   localparam logic [2:0] S_WRN  = 3'd5;
   localparam logic [2:0] S_WRT  = 3'd6;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;
   logic       accept;

   // result register can take a new item
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   // commands
   always_comb begin
      cmd         = '0;
      cmd.clr_wr  = (state_ff == S_CLR);
      cmd.accept  = accept;
      cmd.rd_nb   = (state_ff == S_RDN);
      cmd.cap_tgt = (state_ff == S_RDN);
      cmd.calc    = (state_ff == S_CALC);
      cmd.wr_nb   = (state_ff == S_WRN);
      cmd.wr_tgt  = (state_ff == S_WRT) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLR: begin
            if (status.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_RDT;
         end
         S_RDT:  state_in = S_RDN;
         S_RDN:  state_in = S_CALC;
         S_CALC: state_in = status.is_update ? S_WRN : S_WRT;
         S_WRN:  state_in = S_WRT;
         S_WRT: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.wr_tgt) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `STLU_ASSERT_NXT(a_accept_starts_read, clock, reset, accept, state_ff == S_RDT)
   `STLU_ASSERT_NXT(a_commit_waits, clock, reset, state_ff == S_WRT && !out_free,
                    state_ff == S_WRT && rsp_valid_ff)
   `STLU_ASSERT_IMP(a_result_from_commit, clock, reset, !rsp_valid_ff ##1 rsp_valid_ff,
                    $past(state_ff) == S_WRT)

endmodule

// ===== hw/rtl/stlu_datapath.sv =====
// ----------------------------------------------------------------------------
// stlu_datapath
// Grid memory, clear pointer, settings, species counts and update logic.
// ----------------------------------------------------------------------------
`include "stochastic_tumor_lattice_update_core_assert.svh"

module stlu_datapath #(
   parameter int ROWS = stlu_pkg::DEF_ROWS,
   parameter int COLS = stlu_pkg::DEF_COLS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  stlu_pkg::ctl_cmd_type               cmd,
   output stlu_pkg::ctl_status_type            status,
   input  logic [stlu_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic                                req_tuser,
   input  logic                                csr_valid,
   input  logic [stlu_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [stlu_pkg::CSR_DATA_W-1:0]     csr_data,
   output logic [stlu_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);

   localparam int RW    = $clog2(ROWS);
   localparam int CW    = $clog2(COLS);
   localparam int DEPTH = ROWS * COLS;
   localparam int AW    = $clog2(DEPTH);
   localparam int POS_N = 1 << stlu_pkg::POS_W;

   localparam int SW = stlu_pkg::SPEC_W;
   localparam int FW = stlu_pkg::FRAC_W;
   localparam int PW = stlu_pkg::PACK_W;
   localparam int NW = stlu_pkg::CNT_W;
   localparam int NC = stlu_pkg::NUM_CNT;

   // growth rate of a species, zero for empty or unused codes
   function automatic logic [FW-1:0] rate_of(input logic [PW-1:0] rates,
                                             input logic [SW-1:0] s);
      logic [FW-1:0] r;
      case (s)
         3'd1:    r = rates[0*FW +: FW];
         3'd2:    r = rates[1*FW +: FW];
         3'd3:    r = rates[2*FW +: FW];
         3'd4:    r = rates[3*FW +: FW];
         3'd5:    r = rates[4*FW +: FW];
         default: r = '0;
      endcase
      return r;
   endfunction

   // first child index whose cumulative probability exceeds the draw, else the last in use
   function automatic logic [SW-1:0] pick_child(input logic [PW-1:0] row,
                                                input logic [FW-1:0] rnd,
                                                input logic [SW-1:0] n);
      logic [stlu_pkg::ACC_W-1:0] acc;
      logic                       found;
      logic [SW-1:0]              idx;
      acc   = '0;
      found = 1'b0;
      idx   = n - SW'(1);
      for (int i = 0; i < stlu_pkg::NUM_SPEC; i++) begin
         acc = acc + stlu_pkg::ACC_W'(row[i*FW +: FW]);
         if (!found && (SW'(i) < n) && (stlu_pkg::ACC_W'(rnd) < acc)) begin
            found = 1'b1;
            idx   = SW'(i);
         end
      end
      return idx;
   endfunction

   // settings
   logic [PW-1:0] growth_ff;
   logic [FW-1:0] diffuse_ff;
   logic [SW-1:0] species_ff;
   logic [PW-1:0] mut_ff [stlu_pkg::NUM_SPEC];

   // captured item
   logic          op_ff;
   logic [RW-1:0] r_ff;
   logic [CW-1:0] c_ff;
   logic [SW-1:0] ls_ff;
   logic [stlu_pkg::DIR_W-1:0] dir_ff;
   logic [FW-1:0] rg_ff;
   logic [FW-1:0] rm_ff;
   logic [FW-1:0] rc_ff;
   logic [FW-1:0] rd_ff;

   // grid and access
   logic [SW-1:0] grid_mem [DEPTH];
   logic [SW-1:0] rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [SW-1:0] wr_data;
   logic [AW-1:0] clr_addr_ff;

   // position wrap tables
   logic [RW-1:0] row_lut [POS_N];
   logic [CW-1:0] col_lut [POS_N];

   // neighbor and addresses
   logic [RW-1:0] nr;
   logic [CW-1:0] nc;
   logic [AW-1:0] ti;
   logic [AW-1:0] ni;

   // evaluation
   logic [SW-1:0] t_ff;
   logic [SW-1:0] nb;
   logic [SW-1:0] used_n;
   logic [PW-1:0] mut_row;
   logic [SW-1:0] child;
   logic          rep;
   logic          comp;
   logic          dif;
   logic          load_ok;
   logic [SW-1:0] nb1;
   logic [SW-1:0] t1;
   logic [SW-1:0] tgt_new_in;
   logic [SW-1:0] nb_new_in;
   logic [NC-1:0] inc_in;
   logic [NC-1:0] dec_in;
   logic [SW-1:0] tgt_new_ff;
   logic [SW-1:0] nb_new_ff;
   logic [NC-1:0] inc_ff;
   logic [NC-1:0] dec_ff;

   // result and counts
   logic [SW-1:0] res_tgt_ff;
   logic [SW-1:0] res_nb_ff;
   logic [NW-1:0] cnt_ff [NC];

   // modulo tables, worked out at elaboration
   for (genvar k = 0; k < POS_N; k++) begin : g_wrap
      assign row_lut[k] = RW'(k % ROWS);
      assign col_lut[k] = CW'(k % COLS);
   end

   // settings writes
   always_ff @(posedge clock) begin
      if (reset) begin
         growth_ff  <= '0;
         diffuse_ff <= '0;
         species_ff <= stlu_pkg::SPEC_MAX;
         for (int i = 0; i < stlu_pkg::NUM_SPEC; i++) mut_ff[i] <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            stlu_pkg::REG_GROWTH:  growth_ff  <= csr_data;
            stlu_pkg::REG_DIFFUSE: diffuse_ff <= csr_data[FW-1:0];
            stlu_pkg::REG_SPECIES: species_ff <= csr_data[SW-1:0];
            stlu_pkg::REG_MUT1:    mut_ff[0]  <= csr_data;
            stlu_pkg::REG_MUT2:    mut_ff[1]  <= csr_data;
            stlu_pkg::REG_MUT3:    mut_ff[2]  <= csr_data;
            stlu_pkg::REG_MUT4:    mut_ff[3]  <= csr_data;
            stlu_pkg::REG_MUT5:    mut_ff[4]  <= csr_data;
            default: ;
         endcase
      end
   end

   // capture the item, positions wrapped onto the grid
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req_tuser;
         r_ff   <= row_lut[req_tdata[5:0]];
         c_ff   <= col_lut[req_tdata[11:6]];
         ls_ff  <= req_tdata[14:12];
         dir_ff <= req_tdata[17:15];
         rg_ff  <= req_tdata[29:18];
         rm_ff  <= req_tdata[41:30];
         rc_ff  <= req_tdata[53:42];
         rd_ff  <= req_tdata[65:54];
      end
   end

   // toroidal neighbor
   always_comb begin
      nr = r_ff;
      nc = c_ff;
      if (dir_ff <= stlu_pkg::DIR_UP_LAST) begin
         nr = (r_ff == '0) ? RW'(ROWS - 1) : r_ff - RW'(1);
      end
      if (dir_ff >= stlu_pkg::DIR_DOWN_FIRST) begin
         nr = (r_ff == RW'(ROWS - 1)) ? '0 : r_ff + RW'(1);
      end
      if (dir_ff == stlu_pkg::DIR_UP_LEFT || dir_ff == stlu_pkg::DIR_LEFT ||
          dir_ff == stlu_pkg::DIR_DOWN_LEFT) begin
         nc = (c_ff == '0) ? CW'(COLS - 1) : c_ff - CW'(1);
      end
      if (dir_ff == stlu_pkg::DIR_UP_RIGHT || dir_ff == stlu_pkg::DIR_RIGHT ||
          dir_ff == stlu_pkg::DIR_DOWN_RIGHT) begin
         nc = (c_ff == CW'(COLS - 1)) ? '0 : c_ff + CW'(1);
      end
   end

   assign ti = AW'(r_ff) * AW'(COLS) + AW'(c_ff);
   assign ni = AW'(nr) * AW'(COLS) + AW'(nc);

   // memory port selection
   assign rd_addr = cmd.rd_nb ? ni : ti;
   always_comb begin
      wr_en   = cmd.clr_wr || cmd.wr_nb || cmd.wr_tgt;
      wr_addr = ti;
      wr_data = tgt_new_ff;
      if (cmd.clr_wr) begin
         wr_addr = clr_addr_ff;
         wr_data = stlu_pkg::SPEC_EMPTY;
      end else if (cmd.wr_nb) begin
         wr_addr = ni;
         wr_data = nb_new_ff;
      end
   end

   // grid memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) grid_mem[wr_addr] <= wr_data;
      rd_data_ff <= grid_mem[rd_addr];
   end

   // clear pointer
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_addr_ff <= clr_addr_ff + AW'(1);
      end
   end

   assign status.clr_last  = (clr_addr_ff == AW'(DEPTH - 1));
   assign status.is_update = (op_ff == stlu_pkg::OP_UPDATE);

   // target cell read data
   always_ff @(posedge clock) begin
      if (cmd.cap_tgt) t_ff <= rd_data_ff;
   end

   // species in use clamped to its legal range
   always_comb begin
      if (species_ff < stlu_pkg::SPEC_MIN) begin
         used_n = stlu_pkg::SPEC_MIN;
      end else if (species_ff > stlu_pkg::SPEC_MAX) begin
         used_n = stlu_pkg::SPEC_MAX;
      end else begin
         used_n = species_ff;
      end
   end

   always_comb begin
      case (t_ff)
         3'd1:    mut_row = mut_ff[0];
         3'd2:    mut_row = mut_ff[1];
         3'd3:    mut_row = mut_ff[2];
         3'd4:    mut_row = mut_ff[3];
         3'd5:    mut_row = mut_ff[4];
         default: mut_row = '0;
      endcase
   end

   // replication, competition, diffusion; or the load
   always_comb begin
      nb      = rd_data_ff;
      child   = pick_child(mut_row, rm_ff, used_n) + SW'(1);
      rep     = (t_ff != stlu_pkg::SPEC_EMPTY) && (nb == stlu_pkg::SPEC_EMPTY) &&
                (rg_ff < rate_of(growth_ff, t_ff));
      nb1     = rep ? child : nb;
      comp    = (t_ff != stlu_pkg::SPEC_EMPTY) && (nb1 != stlu_pkg::SPEC_EMPTY) &&
                (rc_ff < rate_of(growth_ff, nb1));
      t1      = comp ? stlu_pkg::SPEC_EMPTY : t_ff;
      dif     = (nb1 != stlu_pkg::SPEC_EMPTY) && (t1 != stlu_pkg::SPEC_EMPTY) &&
                (rd_ff < diffuse_ff);
      load_ok = (ls_ff <= used_n);
      if (op_ff == stlu_pkg::OP_UPDATE) begin
         tgt_new_in = dif ? nb1 : t1;
         nb_new_in  = dif ? t1 : nb1;
         inc_in     = (rep ? (NC'(1) << child) : '0) | (comp ? NC'(1) : '0);
         dec_in     = (rep ? NC'(1) : '0) | (comp ? (NC'(1) << t_ff) : '0);
      end else begin
         tgt_new_in = load_ok ? ls_ff : t_ff;
         nb_new_in  = stlu_pkg::SPEC_EMPTY;
         inc_in     = load_ok ? (NC'(1) << ls_ff) : '0;
         dec_in     = load_ok ? (NC'(1) << t_ff) : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.calc) begin
         tgt_new_ff <= tgt_new_in;
         nb_new_ff  <= nb_new_in;
         inc_ff     <= inc_in;
         dec_ff     <= dec_in;
      end
   end

   // result fields
   always_ff @(posedge clock) begin
      if (cmd.wr_tgt) begin
         res_tgt_ff <= tgt_new_ff;
         res_nb_ff  <= nb_new_ff;
      end
   end

   // species counts
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff[0] <= NW'(DEPTH);
         for (int i = 1; i < NC; i++) cnt_ff[i] <= '0;
      end else if (cmd.wr_tgt) begin
         for (int i = 0; i < NC; i++) begin
            cnt_ff[i] <= cnt_ff[i] + NW'(inc_ff[i]) - NW'(dec_ff[i]);
         end
      end
   end

   assign rsp_tdata = {4'b0, cnt_ff[5], cnt_ff[4], cnt_ff[3], cnt_ff[2], cnt_ff[1],
                       cnt_ff[0], res_nb_ff, res_tgt_ff};

   `STLU_ASSERT_IMP(a_counts_cover_grid, clock, reset, 1'b1,
                    NW'(cnt_ff[0] + cnt_ff[1] + cnt_ff[2] + cnt_ff[3] + cnt_ff[4] +
                        cnt_ff[5]) == NW'(DEPTH))

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// Lattice update core testbench
// Drives load and update items into the core, keeps a shadow of the grid,
// the species counts and the registers, and checks every result field.
// A short directed pass covers wrap-around, ignored loads, empty targets,
// replication, competition and diffusion. Random phases follow, under
// several register settings and idle patterns, including a long receiver
// hold-off that fills the core.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // widths taken from the package
   localparam int POS_W       = stlu_pkg::POS_W;
   localparam int SPEC_W      = stlu_pkg::SPEC_W;
   localparam int DIR_W       = stlu_pkg::DIR_W;
   localparam int FRAC_W      = stlu_pkg::FRAC_W;
   localparam int CNT_W       = stlu_pkg::CNT_W;
   localparam int NUM_SPEC    = stlu_pkg::NUM_SPEC;
   localparam int NUM_CNT     = stlu_pkg::NUM_CNT;
   localparam int PACK_W      = stlu_pkg::PACK_W;
   localparam int REQ_TDATA_W = stlu_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W = stlu_pkg::RSP_TDATA_W;
   localparam int CSR_IDX_W   = stlu_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W  = stlu_pkg::CSR_DATA_W;

   localparam int GRID_ROWS   = stlu_pkg::DEF_ROWS;
   localparam int GRID_COLS   = stlu_pkg::DEF_COLS;
   localparam int HOLD_CYCLES = 400;

   // straight up has no name in the package
   localparam logic [DIR_W-1:0] DIR_UP = 3'd1;

   // result word layout, lowest field at the bottom
   typedef struct packed {
      logic [3:0]                      pad;
      logic [NUM_CNT-1:0][CNT_W-1:0]   counts;   // [0] empty, [1..5] species
      logic [SPEC_W-1:0]               nb;
      logic [SPEC_W-1:0]               tgt;
   } lattice_rsp_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // shadow of the core's state and registers
   logic [SPEC_W-1:0] lattice_cells [GRID_ROWS*GRID_COLS];
   int unsigned       species_pop [NUM_CNT];
   logic [PACK_W-1:0] growth_shadow;
   logic [FRAC_W-1:0] diffusion_shadow;
   logic [SPEC_W-1:0] nspec_shadow;
   logic [PACK_W-1:0] mutation_shadow [NUM_SPEC];

   lattice_rsp_type pending_outcomes [$];
   lattice_rsp_type want_rsp, got_rsp;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_left = 0;
   logic hold_request = 1'b0;

   int errors = 0;
   int n_sent = 0, n_checked = 0, n_loads = 0, n_ignored = 0, n_updates = 0;
   int n_repl = 0, n_death = 0, n_swap = 0, n_empty_tgt = 0;

   stochastic_tumor_lattice_update_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------

   // species in use, clamped to 1..5
   function automatic int unsigned active_species();
      if (nspec_shadow < stlu_pkg::SPEC_MIN) return stlu_pkg::SPEC_MIN;
      if (nspec_shadow > stlu_pkg::SPEC_MAX) return stlu_pkg::SPEC_MAX;
      return nspec_shadow;
   endfunction

   function automatic logic [FRAC_W-1:0] rate_of_species(logic [SPEC_W-1:0] s);
      int k;
      k = s;
      if (s < stlu_pkg::SPEC_MIN || s > stlu_pkg::SPEC_MAX) return '0;
      return growth_shadow[FRAC_W*(k-1) +: FRAC_W];
   endfunction

   // first child whose cumulative probability exceeds the draw, else the last
   function automatic logic [SPEC_W-1:0] pick_offspring(logic [SPEC_W-1:0] parent,
                                                         logic [FRAC_W-1:0] rnd);
      int unsigned n, acc;
      logic [PACK_W-1:0] row;
      n = active_species();
      acc = 0;
      row = '0;
      if (parent >= stlu_pkg::SPEC_MIN && parent <= stlu_pkg::SPEC_MAX)
         row = mutation_shadow[parent - 1];
      for (int i = 0; i < n; i++) begin
         acc += row[FRAC_W*i +: FRAC_W];
         if (rnd < acc) return SPEC_W'(i + 1);
      end
      return SPEC_W'(n);
   endfunction

   // apply one item to the shadow grid and return the result it must produce
   function automatic lattice_rsp_type apply_lattice_item(
      logic op, logic [POS_W-1:0] row, logic [POS_W-1:0] col, logic [SPEC_W-1:0] spec,
      logic [DIR_W-1:0] dir, logic [FRAC_W-1:0] rg, logic [FRAC_W-1:0] rm,
      logic [FRAC_W-1:0] rc, logic [FRAC_W-1:0] rd);
      int unsigned ti, ni, nr, nc, ri, ci;
      logic [SPEC_W-1:0] t, old, child, tmp, nb_out;
      lattice_rsp_type res;
      ri = row % GRID_ROWS;
      ci = col % GRID_COLS;
      ti = ri * GRID_COLS + ci;
      nb_out = stlu_pkg::SPEC_EMPTY;
      if (op == stlu_pkg::OP_LOAD) begin
         n_loads++;
         if (spec <= active_species()) begin
            old = lattice_cells[ti];
            species_pop[old]--;
            species_pop[spec]++;
            lattice_cells[ti] = spec;
         end else begin
            n_ignored++;
         end
      end else begin
         n_updates++;
         nr = ri;
         nc = ci;
         if (dir <= stlu_pkg::DIR_UP_LAST) nr = (ri + GRID_ROWS - 1) % GRID_ROWS;
         if (dir >= stlu_pkg::DIR_DOWN_FIRST) nr = (ri + 1) % GRID_ROWS;
         if (dir == stlu_pkg::DIR_UP_LEFT || dir == stlu_pkg::DIR_LEFT ||
             dir == stlu_pkg::DIR_DOWN_LEFT)
            nc = (ci + GRID_COLS - 1) % GRID_COLS;
         if (dir == stlu_pkg::DIR_UP_RIGHT || dir == stlu_pkg::DIR_RIGHT ||
             dir == stlu_pkg::DIR_DOWN_RIGHT)
            nc = (ci + 1) % GRID_COLS;
         ni = nr * GRID_COLS + nc;
         if (lattice_cells[ti] == stlu_pkg::SPEC_EMPTY) begin
            n_empty_tgt++;
         end else begin
            t = lattice_cells[ti];
            // replication into an empty neighbor
            if (lattice_cells[ni] == stlu_pkg::SPEC_EMPTY && rg < rate_of_species(t)) begin
               child = pick_offspring(t, rm);
               lattice_cells[ni] = child;
               species_pop[child]++;
               species_pop[stlu_pkg::SPEC_EMPTY]--;
               n_repl++;
            end
            // death by competition
            if (lattice_cells[ni] != stlu_pkg::SPEC_EMPTY &&
                rc < rate_of_species(lattice_cells[ni])) begin
               species_pop[lattice_cells[ti]]--;
               species_pop[stlu_pkg::SPEC_EMPTY]++;
               lattice_cells[ti] = stlu_pkg::SPEC_EMPTY;
               n_death++;
            end
            // diffusion swaps two occupied cells
            if (lattice_cells[ni] != stlu_pkg::SPEC_EMPTY &&
                lattice_cells[ti] != stlu_pkg::SPEC_EMPTY && rd < diffusion_shadow) begin
               tmp = lattice_cells[ni];
               lattice_cells[ni] = lattice_cells[ti];
               lattice_cells[ti] = tmp;
               n_swap++;
            end
         end
         nb_out = lattice_cells[ni];
      end
      res.pad = '0;
      res.tgt = lattice_cells[ti];
      res.nb = nb_out;
      for (int k = 0; k < NUM_CNT; k++) res.counts[k] = CNT_W'(species_pop[k]);
      return res;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic send_item(input logic op, input logic [POS_W-1:0] row,
                            input logic [POS_W-1:0] col, input logic [SPEC_W-1:0] spec,
                            input logic [DIR_W-1:0] dir, input logic [FRAC_W-1:0] rg,
                            input logic [FRAC_W-1:0] rm, input logic [FRAC_W-1:0] rc,
                            input logic [FRAC_W-1:0] rd);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, rd, rc, rm, rg, dir, spec, col, row};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_outcomes.push_back(apply_lattice_item(op, row, col, spec, dir, rg, rm, rc, rd));
      n_sent++;
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         stlu_pkg::REG_GROWTH:  growth_shadow = value;
         stlu_pkg::REG_DIFFUSE: diffusion_shadow = value[FRAC_W-1:0];
         stlu_pkg::REG_SPECIES: nspec_shadow = value[SPEC_W-1:0];
         default:               mutation_shadow[idx - stlu_pkg::REG_MUT1] = value;
      endcase
   endtask

   // write every register; unused upper bits of the narrow ones carry noise
   task automatic program_registers(input logic [PACK_W-1:0] growth,
                                    input logic [FRAC_W-1:0] diffusion,
                                    input logic [SPEC_W-1:0] nspec,
                                    input logic [NUM_SPEC*PACK_W-1:0] mutation);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'({$urandom, $urandom});
      write_reg(stlu_pkg::REG_GROWTH, growth);
      write_reg(stlu_pkg::REG_DIFFUSE, {noise[CSR_DATA_W-1:FRAC_W], diffusion});
      write_reg(stlu_pkg::REG_SPECIES, {noise[CSR_DATA_W-1:SPEC_W], nspec});
      for (int m = 0; m < NUM_SPEC; m++)
         write_reg(CSR_IDX_W'(int'(stlu_pkg::REG_MUT1) + m), mutation[PACK_W*m +: PACK_W]);
      csr_valid <= 1'b0;
   endtask

   // wait until every outstanding result has been checked
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   function automatic logic [FRAC_W-1:0] rand_frac();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick == 0) return '0;
      if (pick == 1) return '1;
      return FRAC_W'($urandom);
   endfunction

   function automatic logic [PACK_W-1:0] rand_packed();
      return PACK_W'({$urandom, $urandom});
   endfunction

   // five child probabilities of moderate size so the running sum spans 4096
   function automatic logic [PACK_W-1:0] rand_mutation_row();
      logic [PACK_W-1:0] row;
      for (int i = 0; i < NUM_SPEC; i++) row[FRAC_W*i +: FRAC_W] = FRAC_W'($urandom_range(1300));
      return row;
   endfunction

   function automatic logic [NUM_SPEC*PACK_W-1:0] rand_mutation_table();
      logic [NUM_SPEC*PACK_W-1:0] tbl;
      for (int m = 0; m < NUM_SPEC; m++) tbl[PACK_W*m +: PACK_W] = rand_mutation_row();
      return tbl;
   endfunction

   // mostly a small window across the wrap corner, so cells meet neighbors
   function automatic logic [POS_W-1:0] rand_pos();
      if ($urandom_range(99) < 85) return POS_W'(GRID_ROWS - 4 + $urandom_range(7));
      return POS_W'($urandom);
   endfunction

   task automatic send_random_item();
      logic op;
      op = ($urandom_range(99) < 35) ? stlu_pkg::OP_LOAD : stlu_pkg::OP_UPDATE;
      send_item(op, rand_pos(), rand_pos(), SPEC_W'($urandom_range(7)),
                DIR_W'($urandom_range(7)), rand_frac(), rand_frac(), rand_frac(),
                rand_frac());
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // reset register values: all rates zero, five species in use
   task automatic test_reset_settings();
      send_item(stlu_pkg::OP_LOAD, 6'd0, 6'd0, stlu_pkg::SPEC_MAX, '0, '0, '0, '0, '0);
      send_item(stlu_pkg::OP_LOAD, 6'd63, 6'd63, 3'd7, '1, '1, '1, '1, '1);
      send_item(stlu_pkg::OP_LOAD, 6'd63, 6'd63, 3'd6, '0, '0, '0, '0, '0);
      send_item(stlu_pkg::OP_LOAD, 6'd63, 6'd0, stlu_pkg::SPEC_MIN, '0, '0, '0, '0, '0);
      send_item(stlu_pkg::OP_LOAD, 6'd0, 6'd63, 3'd3, '0, '0, '0, '0, '0);
      send_item(stlu_pkg::OP_UPDATE, 6'd0, 6'd0, '0, stlu_pkg::DIR_DOWN_RIGHT,
                '0, '0, '0, '0);
      // empty target across the wrap corner
      send_item(stlu_pkg::OP_UPDATE, 6'd63, 6'd63, '0, stlu_pkg::DIR_DOWN_RIGHT,
                '1, '1, '1, '1);
      send_item(stlu_pkg::OP_LOAD, 6'd0, 6'd0, stlu_pkg::SPEC_EMPTY, '0, '0, '0, '0, '0);
   endtask

   // replication, competition, diffusion and every neighbor direction
   task automatic test_update_cases();
      logic [FRAC_W-1:0] draws [7];
      drain_results();
      program_registers({12'd4095, 12'd3000, 12'd2048, 12'd1000, 12'd1}, 12'd4095,
                        stlu_pkg::SPEC_MAX, {NUM_SPEC*NUM_SPEC{12'd800}});
      draws = '{12'd0, 12'd4095, 12'd2000, 12'd799, 12'd800, 12'd3999, 12'd4000};
      send_item(stlu_pkg::OP_LOAD, 6'd0, 6'd0, 3'd2, '0, '0, '0, '0, '0);
      // replicate into the empty corner cell, no death, no swap
      send_item(stlu_pkg::OP_UPDATE, 6'd0, 6'd0, '0, stlu_pkg::DIR_UP_LEFT, '0, '0, '1, '1);
      // occupied neighbor kills the target
      send_item(stlu_pkg::OP_UPDATE, 6'd0, 6'd0, '0, stlu_pkg::DIR_UP_LEFT, '0, '0, '0, '1);
      send_item(stlu_pkg::OP_LOAD, 6'd0, 6'd0, 3'd4, '0, '0, '0, '0, '0);
      // two occupied cells swap
      send_item(stlu_pkg::OP_UPDATE, 6'd0, 6'd0, '0, stlu_pkg::DIR_UP_LEFT, '0, '0, '1, '0);
      for (int d = DIR_UP; d <= stlu_pkg::DIR_DOWN_RIGHT; d++)
         send_item(stlu_pkg::OP_UPDATE, 6'd0, 6'd0, '0, DIR_W'(d), '0, draws[d-1], '1, '1);
   endtask

   task automatic test_random_typical();
      drain_results();
      send_idle_pct = 26;
      recv_idle_pct = 57;
      program_registers(rand_packed(), FRAC_W'($urandom),
                        SPEC_W'($urandom_range(stlu_pkg::SPEC_MIN, stlu_pkg::SPEC_MAX)),
                        rand_mutation_table());
      repeat (300) send_random_item();
   endtask

   // every register bit set
   task automatic test_random_extremes();
      drain_results();
      send_idle_pct = 57;
      recv_idle_pct = 26;
      program_registers('1, '1, '1, '1);
      repeat (300) send_random_item();
   endtask

   // long receiver hold-off while the sender keeps offering items
   task automatic test_backpressure();
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_registers(rand_packed(), '0, '0, '0);
      hold_request = 1'b1;
      repeat (50) send_random_item();
   endtask

   task automatic test_random_no_idle();
      drain_results();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      program_registers(rand_packed(), FRAC_W'($urandom), 3'd6, rand_mutation_table());
      repeat (180) send_random_item();
   endtask

   // ---------------------------------------------------------------------
   // Receiver: random stalls plus an occasional long hold-off
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp = rsp_tdata;
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_tdata);
            errors++;
         end else begin
            want_rsp = pending_outcomes.pop_front();
            n_checked++;
            if (got_rsp.tgt !== want_rsp.tgt) begin
               $display("%0t: target_after expected %0d actual %0d", $time, want_rsp.tgt,
                        got_rsp.tgt);
               errors++;
            end
            if (got_rsp.nb !== want_rsp.nb) begin
               $display("%0t: neighbor_after expected %0d actual %0d", $time, want_rsp.nb,
                        got_rsp.nb);
               errors++;
            end
            for (int k = 0; k < NUM_CNT; k++) begin
               if (got_rsp.counts[k] !== want_rsp.counts[k]) begin
                  $display("%0t: count of species %0d expected %0d actual %0d", $time, k,
                           want_rsp.counts[k], got_rsp.counts[k]);
                  errors++;
               end
            end
            if (got_rsp.pad !== want_rsp.pad) begin
               $display("%0t: pad bits expected %h actual %h", $time, want_rsp.pad,
                        got_rsp.pad);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      growth_shadow = '0;
      diffusion_shadow = '0;
      nspec_shadow = stlu_pkg::SPEC_MAX;
      for (int m = 0; m < NUM_SPEC; m++) mutation_shadow[m] = '0;
      for (int i = 0; i < GRID_ROWS*GRID_COLS; i++) lattice_cells[i] = stlu_pkg::SPEC_EMPTY;
      for (int k = 0; k < NUM_CNT; k++) species_pop[k] = 0;
      species_pop[stlu_pkg::SPEC_EMPTY] = GRID_ROWS * GRID_COLS;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_reset_settings();
      test_update_cases();
      test_random_typical();
      test_random_extremes();
      test_backpressure();
      test_random_no_idle();

      drain_results();
      repeat (20) @(posedge clock);

      $display("covered %0d items: %0d loads (%0d ignored), %0d updates (%0d on empty cells)",
               n_sent, n_loads, n_ignored, n_updates, n_empty_tgt);
      $display("%0d replications, %0d deaths, %0d swaps; %0d results checked, %0d errors",
               n_repl, n_death, n_swap, n_checked, errors);
      if (errors == 0) begin
         $display("stochastic_tumor_lattice_update_core test passed");
      end else begin
         $display("stochastic_tumor_lattice_update_core test failed");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d results outstanding", pending_outcomes.size());
      $display("stochastic_tumor_lattice_update_core test failed");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/stlu_pkg.sv
hw/rtl/stlu_ctrl.sv
hw/rtl/stlu_datapath.sv
hw/rtl/stochastic_tumor_lattice_update_core.sv
tb/tb.sv
